/* sv/qdbi_pkg.sv */
// Shared types, constants and codes for the quadrature detent button input block.
package qdbi_pkg;

    // Saturation bound of the signed step count
    localparam int COUNT_LIMIT = 1000;
    // Detent actions emitted per poll tick at most
    localparam int MAX_DETENTS_PER_TICK = 32;

    localparam int COUNT_W = 11;
    localparam int MAG_W   = 10;
    localparam int DET_W   = $clog2(MAX_DETENTS_PER_TICK + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = COUNT_W'(COUNT_LIMIT);
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -COUNT_W'(COUNT_LIMIT);
    localparam logic [DET_W-1:0] DET_MAX = DET_W'(MAX_DETENTS_PER_TICK);
    localparam logic [7:0] SINCE_SAT = 8'd255;

    // Register reset values
    localparam logic [6:0] STEPS_RST    = 7'd4;
    localparam logic [7:0] CW_RST       = 8'd1;
    localparam logic [7:0] CCW_RST      = 8'd2;
    localparam logic [7:0] PRESS_RST    = 8'd0;
    localparam logic [7:0] DEBOUNCE_RST = 8'd25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEPS_PER_DETENT = 3'd0,
        CFG_INVERT_DIRECTION = 3'd1,
        CFG_CW_CODE          = 3'd2,
        CFG_CCW_CODE         = 3'd3,
        CFG_PRESS_CODE       = 3'd4,
        CFG_DEBOUNCE_MS      = 3'd5,
        CFG_BUTTON_PRESENT   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_CW    = 2'd0,
        KIND_CCW   = 2'd1,
        KIND_PRESS = 2'd2
    } t_kind;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WORK = 1'b1
    } t_state;

    typedef struct packed {
        logic       mode;
        logic       pin_a;
        logic       pin_b;
        logic       button_level;
        logic [9:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] action_code;
        logic [1:0] action_kind;
        logic       last;
    } t_out_item;

    // Commands from controller to datapath
    typedef struct packed {
        logic sample;   // apply a pin sample to the count
        logic tick;     // apply tick timing and button update
        logic emit;     // load the output register
        logic press;    // emitted request is the button press
        logic last;     // emitted request closes the tick
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic det_avail;   // count holds at least one whole detent
        logic more_after;  // another detent remains after this one
        logic press_pend;  // press request waits for this tick
        logic slot_free;   // output register can take a request
    } t_status;

endpackage

/* sv/qdbi_dp.sv */
// Datapath: registers, step count, button debounce and output register.
module qdbi_dp
    import qdbi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_in_item              i_in,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    logic [6:0] r_steps;
    logic       r_invert;
    logic [7:0] r_cw_code;
    logic [7:0] r_ccw_code;
    logic [7:0] r_press_code;
    logic [7:0] r_debounce;
    logic       r_btn_present;

    logic                      r_prev_a, r_prev_b;
    logic signed [COUNT_W-1:0] r_count, n_count;
    logic                      r_btn_state;
    logic [7:0]                r_since, n_since;
    logic                      r_press_pend;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic signed [2:0]         step_a, step_b, step;
    logic signed [COUNT_W:0]   sum;
    logic [6:0]                per;
    logic                      neg;
    logic [MAG_W-1:0]          mag, mag_next;
    logic [10:0]               since_sum;
    logic                      pressed, btn_accept;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps       <= STEPS_RST;
            r_invert      <= 1'b0;
            r_cw_code     <= CW_RST;
            r_ccw_code    <= CCW_RST;
            r_press_code  <= PRESS_RST;
            r_debounce    <= DEBOUNCE_RST;
            r_btn_present <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEPS_PER_DETENT: r_steps       <= i_cfg_wdata[6:0];
                CFG_INVERT_DIRECTION: r_invert      <= i_cfg_wdata[0];
                CFG_CW_CODE:          r_cw_code     <= i_cfg_wdata;
                CFG_CCW_CODE:         r_ccw_code    <= i_cfg_wdata;
                CFG_PRESS_CODE:       r_press_code  <= i_cfg_wdata;
                CFG_DEBOUNCE_MS:      r_debounce    <= i_cfg_wdata;
                CFG_BUTTON_PRESENT:   r_btn_present <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Decode x4: an edge on A counts by B, an edge on B counts by A
    always_comb begin
        step_a = 3'sd0;
        step_b = 3'sd0;
        if (r_prev_a != i_in.pin_a) begin
            step_a = (i_in.pin_a ^ i_in.pin_b) ? 3'sd1 : -3'sd1;
        end
        if (r_prev_b != i_in.pin_b) begin
            step_b = (i_in.pin_a == i_in.pin_b) ? 3'sd1 : -3'sd1;
        end
        step = r_invert ? -(step_a + step_b) : (step_a + step_b);
        sum  = (COUNT_W+1)'(r_count) + (COUNT_W+1)'(step);
    end

    // Magnitude and one-detent subtraction
    always_comb begin
        per      = (r_steps == 7'd0) ? 7'd1 : r_steps;
        neg      = r_count[COUNT_W-1];
        mag      = neg ? MAG_W'(-r_count) : MAG_W'(r_count);
        mag_next = mag - MAG_W'(per);
    end

    // Saturating timer and debounce decision on a tick
    always_comb begin
        since_sum  = 11'(r_since) + 11'(i_in.elapsed_ms);
        n_since    = (since_sum > 11'(SINCE_SAT)) ? SINCE_SAT : since_sum[7:0];
        pressed    = ~i_in.button_level;
        btn_accept = r_btn_present && (pressed != r_btn_state) && (n_since > r_debounce);
    end

    // Next count: saturate on samples, step toward zero on detents
    always_comb begin
        n_count = r_count;
        if (i_cmd.sample) begin
            if (sum > (COUNT_W+1)'(COUNT_MAX)) begin
                n_count = COUNT_MAX;
            end else if (sum < (COUNT_W+1)'(COUNT_MIN)) begin
                n_count = COUNT_MIN;
            end else begin
                n_count = sum[COUNT_W-1:0];
            end
        end else if (i_cmd.emit && !i_cmd.press) begin
            n_count = neg ? r_count + COUNT_W'(per) : r_count - COUNT_W'(per);
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a     <= 1'b0;
            r_prev_b     <= 1'b0;
            r_count      <= '0;
            r_btn_state  <= 1'b0;
            r_since      <= SINCE_SAT;
            r_press_pend <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.sample) begin
                r_prev_a <= i_in.pin_a;
                r_prev_b <= i_in.pin_b;
            end
            if (i_cmd.tick) begin
                r_since      <= btn_accept ? 8'd0 : n_since;
                r_btn_state  <= btn_accept ? pressed : r_btn_state;
                r_press_pend <= btn_accept && pressed && (r_press_code != 8'd0);
            end else if (i_cmd.emit && i_cmd.press) begin
                r_press_pend <= 1'b0;
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.last <= i_cmd.last;
            if (i_cmd.press) begin
                r_out.action_code <= r_press_code;
                r_out.action_kind <= KIND_PRESS;
            end else if (neg) begin
                r_out.action_code <= r_ccw_code;
                r_out.action_kind <= KIND_CCW;
            end else begin
                r_out.action_code <= r_cw_code;
                r_out.action_kind <= KIND_CW;
            end
        end
    end

    assign o_status.det_avail  = mag >= MAG_W'(per);
    assign o_status.more_after = mag_next >= MAG_W'(per);
    assign o_status.press_pend = r_press_pend;
    assign o_status.slot_free  = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_out               = r_out;

    // Count never leaves its saturation bounds
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= COUNT_MAX) && (r_count >= COUNT_MIN))
        else $error("count out of range");

    // A request is loaded only into a free output slot
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("emit into full output register");

    // A press request always closes its tick
    a_press_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.press) |=> (r_out.last && r_out.action_kind == KIND_PRESS))
        else $error("press request not marked last");

    // A pending press means the timer was just restarted
    a_press_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick ##1 r_press_pend) |-> (r_since == 8'd0))
        else $error("press without timer restart");

endmodule

/* sv/qdbi_ctrl.sv */
// Controller: accepts requests and sequences detent and press emission.
module qdbi_ctrl
    import qdbi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_mode,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [DET_W-1:0] r_det_cnt, n_det_cnt;
    logic             det_left, more_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_det_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_det_cnt <= n_det_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_det_cnt  = r_det_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        det_left   = i_status.det_avail && (r_det_cnt != DET_MAX);
        more_left  = i_status.more_after && ((r_det_cnt + DET_W'(1)) != DET_MAX);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == MODE_TICK) begin
                        o_cmd.tick = 1'b1;
                        n_det_cnt  = '0;
                        n_state    = ST_WORK;
                    end else begin
                        o_cmd.sample = 1'b1;
                    end
                end
            end
            ST_WORK: begin
                if (det_left) begin
                    if (i_status.slot_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = !more_left && !i_status.press_pend;
                        n_det_cnt  = r_det_cnt + DET_W'(1);
                    end
                end else if (i_status.press_pend) begin
                    if (i_status.slot_free) begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.press = 1'b1;
                        o_cmd.last  = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Detent count per tick never passes its limit
    a_det_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_det_cnt <= DET_MAX)
        else $error("detent count over limit");

    // No request is accepted while a tick is being worked off
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORK) |-> !o_in_ready && !o_cmd.tick && !o_cmd.sample)
        else $error("request accepted while busy");

endmodule

/* sv/quadrature_detent_button_input.sv */
// Top level: quadrature decoder with detent actions and debounced button press.
// A pin sample yields no request and the block stays idle; the next item follows at once.
// A poll tick yields n requests, where n (0..33) is its detents plus any press request,
// which then closes it; one detent or press goes out per cycle while the slot is free.
// Output stalls stretch a tick for as long as the output register stays full.
// Synchronous active-low reset restores registers and clears count and button state.
module quadrature_detent_button_input
    import qdbi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    qdbi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    qdbi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* sim/quadrature_detent_button_input_tb.sv */
// Self-checking testbench for the quadrature detent button input block.
module quadrature_detent_button_input_tb;
    import qdbi_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX  = 10;

    // Track count, button and timer state; hold the actions each tick must post
    class detent_action_tracker;
        logic [6:0] steps_reg;
        logic       invert_reg;
        logic [7:0] cw_reg;
        logic [7:0] ccw_reg;
        logic [7:0] press_reg;
        logic [7:0] debounce_reg;
        logic       present_reg;
        logic       phase_a;
        logic       phase_b;
        int         count;
        logic       pressed;
        int         since_ms;
        t_out_item  due_actions[$];
        int         errors;
        int         checked;

        function new();
            steps_reg    = STEPS_RST;
            invert_reg   = 1'b0;
            cw_reg       = CW_RST;
            ccw_reg      = CCW_RST;
            press_reg    = PRESS_RST;
            debounce_reg = DEBOUNCE_RST;
            present_reg  = 1'b1;
            phase_a      = 1'b0;
            phase_b      = 1'b0;
            count        = 0;
            pressed      = 1'b0;
            since_ms     = 255;
            errors       = 0;
            checked      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [7:0] value);
            case (idx)
                CFG_STEPS_PER_DETENT: steps_reg    = value[6:0];
                CFG_INVERT_DIRECTION: invert_reg   = value[0];
                CFG_CW_CODE:          cw_reg       = value;
                CFG_CCW_CODE:         ccw_reg      = value;
                CFG_PRESS_CODE:       press_reg    = value;
                CFG_DEBOUNCE_MS:      debounce_reg = value;
                CFG_BUTTON_PRESENT:   present_reg  = value[0];
                default: ;
            endcase
        endfunction

        function void post(logic [7:0] code, t_kind kind);
            t_out_item act;
            act.action_code = code;
            act.action_kind = kind;
            act.last        = 1'b0;
            due_actions.push_back(act);
        endfunction

        // Apply one accepted request to the model state and queue its actions
        function void note_request(t_in_item req);
            int        step_a;
            int        step_b;
            int        per;
            int        mag;
            int        det;
            int        queued;
            logic      negative;
            logic      now_pressed;
            t_out_item tail;
            if (req.mode == MODE_SAMPLE) begin
                // Edge on A counts by level of B, edge on B by level of A
                step_a = (req.pin_a != phase_a) ? ((req.pin_a ^ req.pin_b) ? 1 : -1) : 0;
                step_b = (req.pin_b != phase_b) ? ((req.pin_a == req.pin_b) ? 1 : -1) : 0;
                count += invert_reg ? -(step_a + step_b) : (step_a + step_b);
                if (count > COUNT_LIMIT) count = COUNT_LIMIT;
                if (count < -COUNT_LIMIT) count = -COUNT_LIMIT;
                phase_a = req.pin_a;
                phase_b = req.pin_b;
            end else begin
                queued   = due_actions.size();
                per      = (steps_reg == 7'd0) ? 1 : int'(steps_reg);
                negative = (count < 0);
                mag      = negative ? -count : count;
                det      = mag / per;
                if (det > MAX_DETENTS_PER_TICK) det = MAX_DETENTS_PER_TICK;
                repeat (det) begin
                    if (negative) post(ccw_reg, KIND_CCW);
                    else post(cw_reg, KIND_CW);
                end
                // Keep the remainder and any detents beyond the cap
                mag   = mag - det * per;
                count = negative ? -mag : mag;

                since_ms = since_ms + int'(req.elapsed_ms);
                if (since_ms > 255) since_ms = 255;

                if (present_reg) begin
                    now_pressed = ~req.button_level;
                    if (now_pressed != pressed && since_ms > int'(debounce_reg)) begin
                        pressed  = now_pressed;
                        since_ms = 0;
                        if (now_pressed && press_reg != 8'd0) post(press_reg, KIND_PRESS);
                    end
                end

                // Mark the final action of this tick
                if (due_actions.size() > queued) begin
                    tail      = due_actions.pop_back();
                    tail.last = 1'b1;
                    due_actions.push_back(tail);
                end
            end
        endfunction

        function void report(string what, t_out_item got, t_out_item want);
            errors++;
            if (errors <= REPORT_MAX)
                $display("action %0d %s: got %h/%0d/%b, want %h/%0d/%b",
                         checked, what, got.action_code, got.action_kind, got.last,
                         want.action_code, want.action_kind, want.last);
        endfunction

        // Compare one posted action with the oldest one due
        function void check_action(t_out_item got);
            t_out_item want;
            checked++;
            if (due_actions.size() == 0) begin
                want = '0;
                report("unexpected", got, want);
            end else begin
                want = due_actions.pop_front();
                if (got.action_code !== want.action_code || got.action_kind !== want.action_kind
                        || got.last !== want.last)
                    report("mismatch", got, want);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    detent_action_tracker tracker;
    bit                   calm = 1'b0;
    int                   cycles = 0;
    int                   pin_pos = 0;

    quadrature_detent_button_input dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Observe both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) tracker.note_request(i_in);
            if (o_out_valid && i_out_ready) tracker.check_action(o_out);
        end
    end

    // Stall the action sink a random number of cycles before each action
    initial begin
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Build a pin sample; unused fields carry random values
    function automatic t_in_item pin_sample(logic a, logic b);
        t_in_item req;
        req.mode         = MODE_SAMPLE;
        req.pin_a        = a;
        req.pin_b        = b;
        req.button_level = 1'($urandom);
        req.elapsed_ms   = 10'($urandom);
        case ({a, b})
            2'b00: pin_pos = 0;
            2'b10: pin_pos = 1;
            2'b11: pin_pos = 2;
            default: pin_pos = 3;
        endcase
        return req;
    endfunction

    function automatic t_in_item poll_tick(logic level, logic [9:0] elapsed);
        t_in_item req;
        req.mode         = MODE_TICK;
        req.pin_a        = 1'($urandom);
        req.pin_b        = 1'($urandom);
        req.button_level = level;
        req.elapsed_ms   = elapsed;
        return req;
    endfunction

    // Hold a request until accepted; called and left at a falling edge
    task automatic send_request(t_in_item req);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       = req;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Drain all due actions and let a tick with no action finish
    task automatic settle();
        i_in_valid = 1'b0;
        while (tracker.due_actions.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = value;
        tracker.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_setup(logic [6:0] steps, logic inv, logic [7:0] cw, logic [7:0] ccw,
                              logic [7:0] press, logic [7:0] debounce, logic present);
        write_reg(CFG_STEPS_PER_DETENT, {1'b0, steps});
        write_reg(CFG_INVERT_DIRECTION, {7'd0, inv});
        write_reg(CFG_CW_CODE, cw);
        write_reg(CFG_CCW_CODE, ccw);
        write_reg(CFG_PRESS_CODE, press);
        write_reg(CFG_DEBOUNCE_MS, debounce);
        write_reg(CFG_BUTTON_PRESENT, {7'd0, present});
    endtask

    // Rotate the knob through clean gray-code steps
    task automatic turn(bit forward, int steps);
        int next;
        repeat (steps) begin
            next = (pin_pos + (forward ? 1 : 3)) % 4;
            send_request(pin_sample(next == 1 || next == 2, next == 2 || next == 3));
        end
    endtask

    // Mix rotation bursts, pin noise and poll ticks
    task automatic shuffle_requests(int total);
        int         done;
        int         pick;
        int         len;
        logic [9:0] elapsed;
        done = 0;
        while (done < total) begin
            if ($urandom_range(0, 15) == 0) calm = ~calm;
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
                len = $urandom_range(1, 12);
                turn(1'($urandom), len);
                done += len;
            end else if (pick < 12) begin
                send_request(pin_sample(1'($urandom), 1'($urandom)));
                done++;
            end else begin
                elapsed = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                                      : 10'($urandom_range(0, 40));
                send_request(poll_tick(1'($urandom), elapsed));
                done++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        int phase;
        tracker     = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: one detent each way, cancelling double edges, button timing
        write_reg(CFG_PRESS_CODE, 8'h5A);
        send_request(pin_sample(1'b0, 1'b0));
        turn(1'b1, 4);
        send_request(poll_tick(1'b1, 10'd0));
        send_request(pin_sample(1'b1, 1'b1));
        send_request(pin_sample(1'b0, 1'b0));
        turn(1'b0, 5);
        send_request(poll_tick(1'b0, 10'd1023));
        send_request(poll_tick(1'b1, 10'd0));
        send_request(poll_tick(1'b1, 10'd26));
        send_request(poll_tick(1'b0, 10'd25));
        send_request(poll_tick(1'b0, 10'd1));
        send_request(pin_sample(1'b1, 1'b0));
        send_request(poll_tick(1'b1, 10'd512));
        send_request(poll_tick(1'b1, 10'd0));
        settle();

        // Walk through register settings; drain fully before each change
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    load_setup(7'd1, 1'b0, 8'hFF, 8'h00, 8'hA5, 8'd0, 1'b1);
                    turn(1'b1, 40);
                end
                1: begin
                    load_setup(7'd64, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'd254, 1'b1);
                    turn(1'b1, 16);
                end
                2: load_setup(7'd0, 1'b1, 8'($urandom), 8'($urandom), 8'h00,
                              8'($urandom_range(0, 40)), 1'b1);
                3: begin
                    load_setup(7'd127, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom_range(0, 40)), 1'b0);
                    turn(1'b0, 16);
                end
                default: load_setup(7'($urandom_range(1, 8)), 1'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom_range(1, 255)),
                                    8'($urandom_range(0, 60)), 1'b1);
            endcase
            shuffle_requests(16);
            settle();
        end

        repeat (40) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.due_actions.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
